// ----- src/lme_pkg.sv -----
// shared types and codes of the linked multimap engine
`default_nettype none
package lme_pkg;

    // default pool sizes
    localparam int KEY_DEPTH_DEF   = 16;
    localparam int VALUE_DEPTH_DEF = 32;

    // operation codes
    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_SEARCH = 2'd2;
    localparam logic [1:0] FUNC_NONE   = 2'd3;

    // result status codes
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // datapath commands
    typedef enum logic [4:0] {
        C_NOP,
        C_CLEAR,
        C_LOAD,
        C_LK_READ,
        C_LK_STEP,
        C_SET_FULL,
        C_AK_RD,
        C_AK_WR1,
        C_AK_WR2,
        C_AV_RD,
        C_AV_WR1,
        C_AV_WR2,
        C_VH_RD,
        C_VH_LD,
        C_RM_READ,
        C_RM_HIT,
        C_RM_STEP,
        C_RM_U1,
        C_RM_U2,
        C_RK_RD,
        C_RK_U1,
        C_RK_U2,
        C_SR_READ,
        C_SR_LATCH,
        C_SR_OUT,
        C_EMIT_FIN
    } cmd_t;

    // datapath status toward the controller
    typedef struct packed {
        logic [1:0] func;
        logic       clr_done;
        logic       kcur_end;
        logic       kmatch;
        logic       kfound;
        logic       full;
        logic       vcur_end;
        logic       vmatch;
        logic       kempty;
        logic       sr_last;
        logic       n_zero;
        logic       out_free;
    } dp_status_t;

endpackage
`default_nettype wire

// ----- src/lme_ram.sv -----
// generic single write port ram with registered read
`default_nettype none
module lme_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- src/lme_dp.sv -----
// datapath of the multimap engine: pools, list pointers, counts, result register
`default_nettype none
module lme_dp #(
    parameter int KEY_DEPTH   = lme_pkg::KEY_DEPTH_DEF,
    parameter int VALUE_DEPTH = lme_pkg::VALUE_DEPTH_DEF,
    parameter int KW          = $clog2(KEY_DEPTH + 1),
    parameter int VW          = $clog2(VALUE_DEPTH + 1)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lme_pkg::cmd_t      cmd,
    output lme_pkg::dp_status_t     status,
    input  wire logic [1:0]         in_func,
    input  wire logic signed [31:0] in_key,
    input  wire logic signed [31:0] in_value,
    input  wire logic               out_ready,
    output logic                    out_valid,
    output logic [1:0]              out_status,
    output logic signed [31:0]      out_value,
    output logic                    out_last,
    output logic [VW-1:0]           out_pairs,
    output logic [KW-1:0]           out_keys
);

    localparam int KAW  = $clog2(KEY_DEPTH);
    localparam int VAW  = $clog2(VALUE_DEPTH);
    localparam int MAXD = (KEY_DEPTH > VALUE_DEPTH) ? KEY_DEPTH : VALUE_DEPTH;
    localparam int NW   = $clog2(MAXD + 1);
    localparam logic [KW-1:0] KNIL = KW'(KEY_DEPTH);
    localparam logic [VW-1:0] VNIL = VW'(VALUE_DEPTH);

    // request and walk registers
    logic [1:0]         func_reg, func_next;
    logic signed [31:0] key_reg, key_next;
    logic signed [31:0] val_reg, val_next;
    logic [KW-1:0]      kcur_reg, kcur_next;
    logic [KW-1:0]      kp_reg, kp_next;
    logic [VW-1:0]      vcur_reg, vcur_next;
    logic [VW-1:0]      pv_reg, pv_next;
    logic [VW-1:0]      nv_reg, nv_next;
    logic [NW-1:0]      n_reg, n_next;
    logic               kfound_reg, kfound_next;
    logic [1:0]         st_reg, st_next;
    logic signed [31:0] fval_reg, fval_next;
    logic [VW-1:0]      vnext_reg, vnext_next;
    // list heads, free heads, counts
    logic [KW-1:0]      khead_reg, khead_next;
    logic [KW-1:0]      ktail_reg, ktail_next;
    logic [KW-1:0]      kfree_reg, kfree_next;
    logic [VW-1:0]      vfree_reg, vfree_next;
    logic [VW-1:0]      pcnt_reg, pcnt_next;
    logic [KW-1:0]      kcnt_reg, kcnt_next;
    // result register
    logic               ov_reg, ov_next;
    logic [1:0]         ost_reg, ost_next;
    logic signed [31:0] oval_reg, oval_next;
    logic               olast_reg, olast_next;
    logic [VW-1:0]      opc_reg, opc_next;
    logic [KW-1:0]      okc_reg, okc_next;

    // memory ports
    logic           kst_we, knx_we, kpv_we, kvh_we, kvt_we, vst_we, vnx_we, vpv_we;
    logic [KAW-1:0] kst_wa, knx_wa, kpv_wa, kvh_wa, kvt_wa;
    logic [KAW-1:0] kst_ra, knx_ra, kpv_ra, kvh_ra, kvt_ra;
    logic [VAW-1:0] vst_wa, vnx_wa, vpv_wa, vst_ra, vnx_ra, vpv_ra;
    logic [31:0]    kst_wd, kst_q, vst_wd, vst_q;
    logic [KW-1:0]  knx_wd, knx_q, kpv_wd, kpv_q;
    logic [VW-1:0]  kvh_wd, kvh_q, kvt_wd, kvt_q;
    logic [VW-1:0]  vnx_wd, vnx_q, vpv_wd, vpv_q;

    logic kmatch, vmatch, sr_last, out_free;

    assign kmatch   = (kst_q == key_reg);
    assign vmatch   = (vst_q == val_reg);
    assign sr_last  = (vnext_reg == VNIL) || (n_reg == NW'(VALUE_DEPTH - 1));
    assign out_free = !ov_reg || out_ready;

    // status toward the controller
    always_comb
    begin
        status.func     = func_reg;
        status.clr_done = (n_reg == NW'(MAXD - 1));
        status.kcur_end = (kcur_reg == KNIL) || (n_reg == NW'(KEY_DEPTH));
        status.kmatch   = kmatch;
        status.kfound   = kfound_reg;
        status.full     = (!kfound_reg && (kfree_reg == KNIL)) || (vfree_reg == VNIL);
        status.vcur_end = (vcur_reg == VNIL) || (n_reg == NW'(VALUE_DEPTH));
        status.vmatch   = vmatch;
        status.kempty   = (pv_reg == VNIL) && (nv_reg == VNIL);
        status.sr_last  = sr_last;
        status.n_zero   = (n_reg == '0);
        status.out_free = out_free;
    end

    // command decode: next register values and memory accesses
    always_comb
    begin
        func_next   = func_reg;
        key_next    = key_reg;
        val_next    = val_reg;
        kcur_next   = kcur_reg;
        kp_next     = kp_reg;
        vcur_next   = vcur_reg;
        pv_next     = pv_reg;
        nv_next     = nv_reg;
        n_next      = n_reg;
        kfound_next = kfound_reg;
        st_next     = st_reg;
        fval_next   = fval_reg;
        vnext_next  = vnext_reg;
        khead_next  = khead_reg;
        ktail_next  = ktail_reg;
        kfree_next  = kfree_reg;
        vfree_next  = vfree_reg;
        pcnt_next   = pcnt_reg;
        kcnt_next   = kcnt_reg;
        ov_next     = ov_reg && !out_ready;
        ost_next    = ost_reg;
        oval_next   = oval_reg;
        olast_next  = olast_reg;
        opc_next    = opc_reg;
        okc_next    = okc_reg;

        kst_we = 1'b0; kst_wa = '0; kst_wd = '0; kst_ra = '0;
        knx_we = 1'b0; knx_wa = '0; knx_wd = '0; knx_ra = '0;
        kpv_we = 1'b0; kpv_wa = '0; kpv_wd = '0; kpv_ra = '0;
        kvh_we = 1'b0; kvh_wa = '0; kvh_wd = '0; kvh_ra = '0;
        kvt_we = 1'b0; kvt_wa = '0; kvt_wd = '0; kvt_ra = '0;
        vst_we = 1'b0; vst_wa = '0; vst_wd = '0; vst_ra = '0;
        vnx_we = 1'b0; vnx_wa = '0; vnx_wd = '0; vnx_ra = '0;
        vpv_we = 1'b0; vpv_wa = '0; vpv_wd = '0; vpv_ra = '0;

        case (cmd)
            lme_pkg::C_CLEAR:
            begin
                // free chains in index order, empty value lists
                if (n_reg < NW'(KEY_DEPTH))
                begin
                    knx_we = 1'b1; knx_wa = n_reg[KAW-1:0]; knx_wd = KW'(n_reg + NW'(1));
                    kpv_we = 1'b1; kpv_wa = n_reg[KAW-1:0]; kpv_wd = KNIL;
                    kvh_we = 1'b1; kvh_wa = n_reg[KAW-1:0]; kvh_wd = VNIL;
                    kvt_we = 1'b1; kvt_wa = n_reg[KAW-1:0]; kvt_wd = VNIL;
                end
                if (n_reg < NW'(VALUE_DEPTH))
                begin
                    vnx_we = 1'b1; vnx_wa = n_reg[VAW-1:0]; vnx_wd = VW'(n_reg + NW'(1));
                    vpv_we = 1'b1; vpv_wa = n_reg[VAW-1:0]; vpv_wd = VNIL;
                end
                n_next = n_reg + NW'(1);
            end
            lme_pkg::C_LOAD:
            begin
                func_next   = in_func;
                key_next    = in_key;
                val_next    = in_value;
                kcur_next   = khead_reg;
                n_next      = '0;
                kfound_next = 1'b0;
                st_next     = lme_pkg::ST_MISS;
            end
            lme_pkg::C_LK_READ:
            begin
                kst_ra = kcur_reg[KAW-1:0];
                knx_ra = kcur_reg[KAW-1:0];
            end
            lme_pkg::C_LK_STEP:
            begin
                if (kmatch)
                begin
                    kp_next     = kcur_reg;
                    kfound_next = 1'b1;
                    n_next      = '0;
                end
                else
                begin
                    kcur_next = knx_q;
                    n_next    = n_reg + NW'(1);
                end
            end
            lme_pkg::C_SET_FULL:
            begin
                st_next = lme_pkg::ST_FULL;
            end
            lme_pkg::C_AK_RD:
            begin
                knx_ra  = kfree_reg[KAW-1:0];
                kp_next = kfree_reg;
            end
            lme_pkg::C_AK_WR1:
            begin
                // take a key node and make it the new tail
                kfree_next = knx_q;
                kst_we = 1'b1; kst_wa = kp_reg[KAW-1:0]; kst_wd = key_reg;
                kvh_we = 1'b1; kvh_wa = kp_reg[KAW-1:0]; kvh_wd = VNIL;
                kvt_we = 1'b1; kvt_wa = kp_reg[KAW-1:0]; kvt_wd = VNIL;
                knx_we = 1'b1; knx_wa = kp_reg[KAW-1:0]; knx_wd = KNIL;
                kpv_we = 1'b1; kpv_wa = kp_reg[KAW-1:0]; kpv_wd = ktail_reg;
            end
            lme_pkg::C_AK_WR2:
            begin
                if (ktail_reg != KNIL)
                begin
                    knx_we = 1'b1; knx_wa = ktail_reg[KAW-1:0]; knx_wd = kp_reg;
                end
                ktail_next = kp_reg;
                if (khead_reg == KNIL)
                begin
                    khead_next = kp_reg;
                end
                kcnt_next = kcnt_reg + KW'(1);
            end
            lme_pkg::C_AV_RD:
            begin
                vnx_ra    = vfree_reg[VAW-1:0];
                kvt_ra    = kp_reg[KAW-1:0];
                kvh_ra    = kp_reg[KAW-1:0];
                vcur_next = vfree_reg;
            end
            lme_pkg::C_AV_WR1:
            begin
                // take a value node and append it to the key's list
                vfree_next = vnx_q;
                pv_next    = kvt_q;
                vst_we = 1'b1; vst_wa = vcur_reg[VAW-1:0]; vst_wd = val_reg;
                vnx_we = 1'b1; vnx_wa = vcur_reg[VAW-1:0]; vnx_wd = VNIL;
                vpv_we = 1'b1; vpv_wa = vcur_reg[VAW-1:0]; vpv_wd = kvt_q;
                kvt_we = 1'b1; kvt_wa = kp_reg[KAW-1:0];   kvt_wd = vcur_reg;
                if (kvh_q == VNIL)
                begin
                    kvh_we = 1'b1; kvh_wa = kp_reg[KAW-1:0]; kvh_wd = vcur_reg;
                end
            end
            lme_pkg::C_AV_WR2:
            begin
                if (pv_reg != VNIL)
                begin
                    vnx_we = 1'b1; vnx_wa = pv_reg[VAW-1:0]; vnx_wd = vcur_reg;
                end
                pcnt_next = pcnt_reg + VW'(1);
                st_next   = lme_pkg::ST_DONE;
            end
            lme_pkg::C_VH_RD:
            begin
                kvh_ra = kp_reg[KAW-1:0];
            end
            lme_pkg::C_VH_LD:
            begin
                vcur_next = kvh_q;
                n_next    = '0;
            end
            lme_pkg::C_RM_READ:
            begin
                vst_ra = vcur_reg[VAW-1:0];
                vnx_ra = vcur_reg[VAW-1:0];
                vpv_ra = vcur_reg[VAW-1:0];
            end
            lme_pkg::C_RM_HIT:
            begin
                pv_next = vpv_q;
                nv_next = vnx_q;
            end
            lme_pkg::C_RM_STEP:
            begin
                vcur_next = vnx_q;
                n_next    = n_reg + NW'(1);
            end
            lme_pkg::C_RM_U1:
            begin
                // bridge the neighbors of the removed value node
                if (pv_reg != VNIL)
                begin
                    vnx_we = 1'b1; vnx_wa = pv_reg[VAW-1:0]; vnx_wd = nv_reg;
                end
                else
                begin
                    kvh_we = 1'b1; kvh_wa = kp_reg[KAW-1:0]; kvh_wd = nv_reg;
                end
                if (nv_reg != VNIL)
                begin
                    vpv_we = 1'b1; vpv_wa = nv_reg[VAW-1:0]; vpv_wd = pv_reg;
                end
                else
                begin
                    kvt_we = 1'b1; kvt_wa = kp_reg[KAW-1:0]; kvt_wd = pv_reg;
                end
            end
            lme_pkg::C_RM_U2:
            begin
                vnx_we = 1'b1; vnx_wa = vcur_reg[VAW-1:0]; vnx_wd = vfree_reg;
                vpv_we = 1'b1; vpv_wa = vcur_reg[VAW-1:0]; vpv_wd = VNIL;
                vfree_next = vcur_reg;
                pcnt_next  = pcnt_reg - VW'(1);
                st_next    = lme_pkg::ST_DONE;
            end
            lme_pkg::C_RK_RD:
            begin
                kpv_ra = kp_reg[KAW-1:0];
                knx_ra = kp_reg[KAW-1:0];
            end
            lme_pkg::C_RK_U1:
            begin
                // bridge the neighbors of the emptied key node
                if (kpv_q != KNIL)
                begin
                    knx_we = 1'b1; knx_wa = kpv_q[KAW-1:0]; knx_wd = knx_q;
                end
                else
                begin
                    khead_next = knx_q;
                end
                if (knx_q != KNIL)
                begin
                    kpv_we = 1'b1; kpv_wa = knx_q[KAW-1:0]; kpv_wd = kpv_q;
                end
                else
                begin
                    ktail_next = kpv_q;
                end
            end
            lme_pkg::C_RK_U2:
            begin
                knx_we = 1'b1; knx_wa = kp_reg[KAW-1:0]; knx_wd = kfree_reg;
                kpv_we = 1'b1; kpv_wa = kp_reg[KAW-1:0]; kpv_wd = KNIL;
                kfree_next = kp_reg;
                kcnt_next  = kcnt_reg - KW'(1);
            end
            lme_pkg::C_SR_READ:
            begin
                vst_ra = vcur_reg[VAW-1:0];
                vnx_ra = vcur_reg[VAW-1:0];
            end
            lme_pkg::C_SR_LATCH:
            begin
                fval_next  = vst_q;
                vnext_next = vnx_q;
            end
            lme_pkg::C_SR_OUT:
            begin
                ov_next    = 1'b1;
                ost_next   = lme_pkg::ST_DONE;
                oval_next  = fval_reg;
                olast_next = sr_last;
                opc_next   = pcnt_reg;
                okc_next   = kcnt_reg;
                vcur_next  = vnext_reg;
                n_next     = n_reg + NW'(1);
            end
            lme_pkg::C_EMIT_FIN:
            begin
                ov_next    = 1'b1;
                ost_next   = st_reg;
                oval_next  = '0;
                olast_next = 1'b1;
                opc_next   = pcnt_reg;
                okc_next   = kcnt_reg;
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg     <= '0;
            khead_reg <= KNIL;
            ktail_reg <= KNIL;
            kfree_reg <= '0;
            vfree_reg <= '0;
            pcnt_reg  <= '0;
            kcnt_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            n_reg     <= n_next;
            khead_reg <= khead_next;
            ktail_reg <= ktail_next;
            kfree_reg <= kfree_next;
            vfree_reg <= vfree_next;
            pcnt_reg  <= pcnt_next;
            kcnt_reg  <= kcnt_next;
            ov_reg    <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        key_reg    <= key_next;
        val_reg    <= val_next;
        kcur_reg   <= kcur_next;
        kp_reg     <= kp_next;
        vcur_reg   <= vcur_next;
        pv_reg     <= pv_next;
        nv_reg     <= nv_next;
        kfound_reg <= kfound_next;
        st_reg     <= st_next;
        fval_reg   <= fval_next;
        vnext_reg  <= vnext_next;
        ost_reg    <= ost_next;
        oval_reg   <= oval_next;
        olast_reg  <= olast_next;
        opc_reg    <= opc_next;
        okc_reg    <= okc_next;
    end

    assign out_valid  = ov_reg;
    assign out_status = ost_reg;
    assign out_value  = oval_reg;
    assign out_last   = olast_reg;
    assign out_pairs  = opc_reg;
    assign out_keys   = okc_reg;

    // key pool
    lme_ram #(.WIDTH(32), .DEPTH(KEY_DEPTH)) u_kst (
        .clk(clk), .we(kst_we), .waddr(kst_wa), .wdata(kst_wd), .raddr(kst_ra), .rdata(kst_q)
    );
    lme_ram #(.WIDTH(KW), .DEPTH(KEY_DEPTH)) u_knx (
        .clk(clk), .we(knx_we), .waddr(knx_wa), .wdata(knx_wd), .raddr(knx_ra), .rdata(knx_q)
    );
    lme_ram #(.WIDTH(KW), .DEPTH(KEY_DEPTH)) u_kpv (
        .clk(clk), .we(kpv_we), .waddr(kpv_wa), .wdata(kpv_wd), .raddr(kpv_ra), .rdata(kpv_q)
    );
    lme_ram #(.WIDTH(VW), .DEPTH(KEY_DEPTH)) u_kvh (
        .clk(clk), .we(kvh_we), .waddr(kvh_wa), .wdata(kvh_wd), .raddr(kvh_ra), .rdata(kvh_q)
    );
    lme_ram #(.WIDTH(VW), .DEPTH(KEY_DEPTH)) u_kvt (
        .clk(clk), .we(kvt_we), .waddr(kvt_wa), .wdata(kvt_wd), .raddr(kvt_ra), .rdata(kvt_q)
    );

    // value pool
    lme_ram #(.WIDTH(32), .DEPTH(VALUE_DEPTH)) u_vst (
        .clk(clk), .we(vst_we), .waddr(vst_wa), .wdata(vst_wd), .raddr(vst_ra), .rdata(vst_q)
    );
    lme_ram #(.WIDTH(VW), .DEPTH(VALUE_DEPTH)) u_vnx (
        .clk(clk), .we(vnx_we), .waddr(vnx_wa), .wdata(vnx_wd), .raddr(vnx_ra), .rdata(vnx_q)
    );
    lme_ram #(.WIDTH(VW), .DEPTH(VALUE_DEPTH)) u_vpv (
        .clk(clk), .we(vpv_we), .waddr(vpv_wa), .wdata(vpv_wd), .raddr(vpv_ra), .rdata(vpv_q)
    );

endmodule
`default_nettype wire

// ----- src/lme_ctrl.sv -----
// controller of the multimap engine: sequences list walks and link updates
`default_nettype none
module lme_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire lme_pkg::dp_status_t status,
    output lme_pkg::cmd_t            cmd
);

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_LK_RD,
        S_LK_CHK,
        S_ADD_CHK,
        S_AK_WR1,
        S_AK_WR2,
        S_AV_RD,
        S_AV_WR1,
        S_AV_WR2,
        S_VH_RD,
        S_VH_LD,
        S_RM_RD,
        S_RM_CHK,
        S_RM_U1,
        S_RM_U2,
        S_RK_RD,
        S_RK_U1,
        S_RK_U2,
        S_SR_RD,
        S_SR_LATCH,
        S_SR_OUT,
        S_FIN
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    // next state and command
    always_comb
    begin
        state_next = state_reg;
        cmd        = lme_pkg::C_NOP;
        case (state_reg)
            S_INIT:
            begin
                cmd = lme_pkg::C_CLEAR;
                if (status.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = lme_pkg::C_LOAD;
                    state_next = S_LK_RD;
                end
            end
            S_LK_RD:
            begin
                if (status.func == lme_pkg::FUNC_NONE)
                begin
                    state_next = S_FIN;
                end
                else if (status.kcur_end)
                begin
                    state_next = (status.func == lme_pkg::FUNC_ADD) ? S_ADD_CHK : S_FIN;
                end
                else
                begin
                    cmd        = lme_pkg::C_LK_READ;
                    state_next = S_LK_CHK;
                end
            end
            S_LK_CHK:
            begin
                cmd = lme_pkg::C_LK_STEP;
                if (status.kmatch)
                begin
                    state_next = (status.func == lme_pkg::FUNC_ADD) ? S_ADD_CHK : S_VH_RD;
                end
                else
                begin
                    state_next = S_LK_RD;
                end
            end
            S_ADD_CHK:
            begin
                if (status.full)
                begin
                    cmd        = lme_pkg::C_SET_FULL;
                    state_next = S_FIN;
                end
                else if (!status.kfound)
                begin
                    cmd        = lme_pkg::C_AK_RD;
                    state_next = S_AK_WR1;
                end
                else
                begin
                    state_next = S_AV_RD;
                end
            end
            S_AK_WR1:
            begin
                cmd        = lme_pkg::C_AK_WR1;
                state_next = S_AK_WR2;
            end
            S_AK_WR2:
            begin
                cmd        = lme_pkg::C_AK_WR2;
                state_next = S_AV_RD;
            end
            S_AV_RD:
            begin
                cmd        = lme_pkg::C_AV_RD;
                state_next = S_AV_WR1;
            end
            S_AV_WR1:
            begin
                cmd        = lme_pkg::C_AV_WR1;
                state_next = S_AV_WR2;
            end
            S_AV_WR2:
            begin
                cmd        = lme_pkg::C_AV_WR2;
                state_next = S_FIN;
            end
            S_VH_RD:
            begin
                cmd        = lme_pkg::C_VH_RD;
                state_next = S_VH_LD;
            end
            S_VH_LD:
            begin
                cmd        = lme_pkg::C_VH_LD;
                state_next = (status.func == lme_pkg::FUNC_REMOVE) ? S_RM_RD : S_SR_RD;
            end
            S_RM_RD:
            begin
                if (status.vcur_end)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd        = lme_pkg::C_RM_READ;
                    state_next = S_RM_CHK;
                end
            end
            S_RM_CHK:
            begin
                if (status.vmatch)
                begin
                    cmd        = lme_pkg::C_RM_HIT;
                    state_next = S_RM_U1;
                end
                else
                begin
                    cmd        = lme_pkg::C_RM_STEP;
                    state_next = S_RM_RD;
                end
            end
            S_RM_U1:
            begin
                cmd        = lme_pkg::C_RM_U1;
                state_next = S_RM_U2;
            end
            S_RM_U2:
            begin
                cmd        = lme_pkg::C_RM_U2;
                state_next = status.kempty ? S_RK_RD : S_FIN;
            end
            S_RK_RD:
            begin
                cmd        = lme_pkg::C_RK_RD;
                state_next = S_RK_U1;
            end
            S_RK_U1:
            begin
                cmd        = lme_pkg::C_RK_U1;
                state_next = S_RK_U2;
            end
            S_RK_U2:
            begin
                cmd        = lme_pkg::C_RK_U2;
                state_next = S_FIN;
            end
            S_SR_RD:
            begin
                if (status.vcur_end)
                begin
                    state_next = status.n_zero ? S_FIN : S_IDLE;
                end
                else
                begin
                    cmd        = lme_pkg::C_SR_READ;
                    state_next = S_SR_LATCH;
                end
            end
            S_SR_LATCH:
            begin
                cmd        = lme_pkg::C_SR_LATCH;
                state_next = S_SR_OUT;
            end
            S_SR_OUT:
            begin
                if (status.out_free)
                begin
                    cmd        = lme_pkg::C_SR_OUT;
                    state_next = status.sr_last ? S_IDLE : S_SR_RD;
                end
            end
            S_FIN:
            begin
                if (status.out_free)
                begin
                    cmd        = lme_pkg::C_EMIT_FIN;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ----- src/linked_multimap_engine_unit.sv -----
// top level of the linked multimap engine
//
// Stores key/value pairs in two node pools (KEY_DEPTH key nodes, VALUE_DEPTH
// value nodes) kept as doubly linked lists in single-port-read RAMs. One
// request is worked at a time. After reset a clearing pass builds the free
// chains; no request is taken during it. Every step of a walk is one RAM read
// with registered data. An add takes a key node if the key is new and then
// appends a value node, a remove walks the key's values and unlinks the
// first match, freeing the key node when its list empties, and a search
// presents one result per value returned. The next request is taken while
// the last result still waits in the output register.
`default_nettype none
module linked_multimap_engine_unit #(
    parameter int KEY_DEPTH   = lme_pkg::KEY_DEPTH_DEF,
    parameter int VALUE_DEPTH = lme_pkg::VALUE_DEPTH_DEF,
    parameter int KW          = $clog2(KEY_DEPTH + 1),
    parameter int VW          = $clog2(VALUE_DEPTH + 1),
    parameter int OW          = ((32 + VW + KW + 7) / 8) * 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [63:0]   s_tdata,   // item_key, item_value
    input  wire logic [1:0]    s_tuser,   // func
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [OW-1:0]      m_tdata,   // found_value, pair_total, key_total, zero fill
    output logic [1:0]         m_tuser,   // status
    output logic               m_tlast
);

    lme_pkg::cmd_t       cmd;
    lme_pkg::dp_status_t status;
    logic signed [31:0]  out_value;
    logic [VW-1:0]       out_pairs;
    logic [KW-1:0]       out_keys;

    // sequencer
    lme_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // pools, pointers and result register
    lme_dp #(
        .KEY_DEPTH   (KEY_DEPTH),
        .VALUE_DEPTH (VALUE_DEPTH),
        .KW          (KW),
        .VW          (VW)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .in_func    (s_tuser),
        .in_key     (s_tdata[31:0]),
        .in_value   (s_tdata[63:32]),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_status (m_tuser),
        .out_value  (out_value),
        .out_last   (m_tlast),
        .out_pairs  (out_pairs),
        .out_keys   (out_keys)
    );

    // result packing
    assign m_tdata = OW'({out_keys, out_pairs, out_value});

endmodule
`default_nettype wire

// ----- tb/lme_checker.sv -----
// result checker for the linked multimap engine: mirrors the multimap and compares results
`timescale 1ns / 1ps
`default_nettype none
module lme_checker #(
    parameter int KD = 16,
    parameter int VD = 32,
    parameter int OW = 48
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    input  wire logic          s_tready,
    input  wire logic [63:0]   s_tdata,
    input  wire logic [1:0]    s_tuser,
    input  wire logic          m_tvalid,
    input  wire logic          m_tready,
    input  wire logic [OW-1:0] m_tdata,
    input  wire logic [1:0]    m_tuser,
    input  wire logic          m_tlast,
    output int                 fail_count,
    output int                 pending,
    output int                 result_count
);

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found;
        logic        last;
        logic [5:0]  pairs;
        logic [4:0]  keys;
    } outcome_t;

    // mirror of the multimap: keys in first-add order, each with its value list
    logic [31:0] key_order[$];
    logic [31:0] vals_of[logic [31:0]][$];
    int          pair_cnt;
    outcome_t    awaited[$];

    assign pending = awaited.size();

    function automatic int find_key(logic [31:0] k);
        foreach (key_order[i])
            if (key_order[i] == k)
                return i;
        return -1;
    endfunction

    function automatic void push_outcome(logic [1:0] st, logic [31:0] v, logic l);
        outcome_t o;
        o.status = st;
        o.found  = v;
        o.last   = l;
        o.pairs  = pair_cnt[5:0];
        o.keys   = 5'(key_order.size());
        awaited = {awaited, o};
    endfunction

    // apply one request to the mirror and queue what it should produce
    function automatic void apply_request(logic [1:0] op, logic [31:0] k, logic [31:0] v);
        int ki;
        int hit;
        ki = find_key(k);
        case (op)
            lme_pkg::FUNC_ADD:
            begin
                if ((ki < 0 && key_order.size() >= KD) || pair_cnt >= VD)
                    push_outcome(lme_pkg::ST_FULL, '0, 1'b1);
                else
                begin
                    if (ki < 0)
                        key_order = {key_order, k};
                    vals_of[k] = {vals_of[k], v};
                    pair_cnt++;
                    push_outcome(lme_pkg::ST_DONE, '0, 1'b1);
                end
            end
            lme_pkg::FUNC_REMOVE:
            begin
                hit = -1;
                if (ki >= 0)
                    foreach (vals_of[k][i])
                        if (hit < 0 && vals_of[k][i] == v)
                            hit = i;
                if (hit < 0)
                    push_outcome(lme_pkg::ST_MISS, '0, 1'b1);
                else
                begin
                    vals_of[k].delete(hit);
                    pair_cnt--;
                    if (vals_of[k].size() == 0)
                    begin
                        vals_of.delete(k);
                        key_order.delete(ki);
                    end
                    push_outcome(lme_pkg::ST_DONE, '0, 1'b1);
                end
            end
            lme_pkg::FUNC_SEARCH:
            begin
                if (ki < 0)
                    push_outcome(lme_pkg::ST_MISS, '0, 1'b1);
                else
                    foreach (vals_of[k][i])
                        push_outcome(lme_pkg::ST_DONE, vals_of[k][i],
                                     i == vals_of[k].size() - 1);
            end
            default:
                push_outcome(lme_pkg::ST_MISS, '0, 1'b1);
        endcase
    endfunction

    // watch both channels
    always @(posedge clk or negedge rst_n)
    begin
        outcome_t o;
        if (!rst_n)
        begin
            key_order.delete();
            vals_of.delete();
            awaited.delete();
            pair_cnt     = 0;
            fail_count   = 0;
            result_count = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                result_count++;
                if (awaited.size() == 0)
                begin
                    $error("unexpected result: status %0d data %h", m_tuser, m_tdata);
                    fail_count++;
                end
                else
                begin
                    o = awaited.pop_front();
                    if (m_tuser !== o.status)
                    begin
                        $error("status: expected %0d actual %0d", o.status, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[31:0] !== o.found)
                    begin
                        $error("found_value: expected %0d actual %0d",
                               $signed(o.found), $signed(m_tdata[31:0]));
                        fail_count++;
                    end
                    if (m_tlast !== o.last)
                    begin
                        $error("last: expected %0d actual %0d", o.last, m_tlast);
                        fail_count++;
                    end
                    if (m_tdata[37:32] !== o.pairs)
                    begin
                        $error("pair_total: expected %0d actual %0d", o.pairs, m_tdata[37:32]);
                        fail_count++;
                    end
                    if (m_tdata[42:38] !== o.keys)
                    begin
                        $error("key_total: expected %0d actual %0d", o.keys, m_tdata[42:38]);
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                apply_request(s_tuser, s_tdata[31:0], s_tdata[63:32]);
        end
    end

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// stimulus and verdict for the linked multimap engine
`timescale 1ns / 1ps
`default_nettype none
module testbench;

    localparam int OW = 48;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [63:0]   s_tdata = '0;
    logic [1:0]    s_tuser = lme_pkg::FUNC_ADD;
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [OW-1:0] m_tdata;
    logic [1:0]    m_tuser;
    logic          m_tlast;
    int            fail_count;
    int            pending;
    int            result_count;
    int            request_count = 0;
    logic [31:0]   key_pool[8];

    always #2 clk = ~clk;

    linked_multimap_engine_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    lme_checker #(.KD(16), .VD(32), .OW(OW)) u_checker (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .fail_count(fail_count), .pending(pending), .result_count(result_count)
    );

    // receiver stall pattern: long ready stretches, stall bursts, random flicker
    always @(posedge clk)
    begin
        int phase;
        phase = (result_count / 40) % 3;
        if (phase == 0)
            m_tready <= 1'b1;
        else if (phase == 1)
            m_tready <= ($urandom_range(0, 3) != 0);
        else
            m_tready <= ($urandom_range(0, 2) == 0);
    end

    // one request, held until accepted, with an optional gap before it
    task automatic send_request(logic [1:0] op, logic [31:0] k, logic [31:0] v, int gap);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {v, k};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        request_count++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int burst;
        int r;
        int gap;
        logic [1:0]  op;
        logic [31:0] k;
        logic [31:0] v;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        foreach (key_pool[i])
            key_pool[i] = $urandom;
        key_pool[0] = 32'h8000_0000;
        key_pool[1] = 32'h7fff_ffff;

        // directed: extremes, empty search, removes that miss, unused code
        send_request(lme_pkg::FUNC_SEARCH, 32'h8000_0000, '0, 0);
        send_request(lme_pkg::FUNC_REMOVE, 32'h8000_0000, '0, 0);
        send_request(lme_pkg::FUNC_NONE, 32'hffff_ffff, 32'hffff_ffff, 0);
        send_request(lme_pkg::FUNC_ADD, 32'h8000_0000, 32'h7fff_ffff, 0);
        send_request(lme_pkg::FUNC_ADD, 32'h8000_0000, 32'h8000_0000, 0);
        send_request(lme_pkg::FUNC_ADD, 32'h8000_0000, 32'h7fff_ffff, 0);
        send_request(lme_pkg::FUNC_ADD, 32'h7fff_ffff, 32'h0, 0);
        send_request(lme_pkg::FUNC_SEARCH, 32'h8000_0000, '0, 0);
        send_request(lme_pkg::FUNC_REMOVE, 32'h8000_0000, 32'h1, 0);
        send_request(lme_pkg::FUNC_REMOVE, 32'h8000_0000, 32'h7fff_ffff, 0);
        send_request(lme_pkg::FUNC_SEARCH, 32'h8000_0000, '0, 0);
        send_request(lme_pkg::FUNC_REMOVE, 32'h7fff_ffff, 32'h0, 0);
        send_request(lme_pkg::FUNC_SEARCH, 32'h7fff_ffff, '0, 0);
        wait_drained();

        // fill the key pool past full, then the value pool past full
        for (int i = 0; i < 17; i++)
            send_request(lme_pkg::FUNC_ADD, 32'h100 + i, $urandom, $urandom_range(0, 1));
        for (int i = 0; i < 18; i++)
            send_request(lme_pkg::FUNC_ADD, 32'h100, $urandom, 0);
        send_request(lme_pkg::FUNC_SEARCH, 32'h100, '0, 0);
        send_request(lme_pkg::FUNC_REMOVE, 32'h8000_0000, 32'h7fff_ffff, 0);
        wait_drained();
        // search the first 16 keys of the fill, one of the two that never fit included
        for (int i = 0; i < 16; i++)
            send_request(lme_pkg::FUNC_SEARCH, 32'h100 + i, '0, 0);
        wait_drained();

        // random bursts over a small key set so keys collide
        while (request_count < 130)
        begin
            burst = $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            for (int b = 0; b < burst; b++)
            begin
                r = $urandom_range(0, 99);
                op = (r < 45) ? lme_pkg::FUNC_ADD : (r < 75) ? lme_pkg::FUNC_REMOVE :
                     (r < 97) ? lme_pkg::FUNC_SEARCH : lme_pkg::FUNC_NONE;
                k = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, 7)];
                v = ($urandom_range(0, 1) != 0) ? $urandom : {29'd0, 3'($urandom_range(0, 7))};
                send_request(op, k, v, (b == 0) ? gap : 0);
            end
            if ($urandom_range(0, 15) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (200) @(posedge clk);
        $display("run covered %0d requests and %0d results, with pools driven past full",
                 request_count, result_count);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
`default_nettype wire
